// ===== hw/rtl/tsq_pkg.sv =====
`default_nettype none

package tsq_pkg;

    localparam int PIN_W = 49;

    localparam logic [1:0] OP_STEP    = 2'd0;
    localparam logic [1:0] OP_ENQUEUE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [1:0] KIND_COLOR = 2'd0;
    localparam logic [1:0] KIND_BLINK = 2'd1;
    localparam logic [1:0] KIND_PIN   = 2'd2;
    localparam logic [1:0] KIND_WAIT  = 2'd3;

    localparam logic [2:0] ISSUE_LED_OFF = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic [4:0]  MAX_TIMES    = 5'd20;
    localparam logic [15:0] MIN_BLINK_MS = 16'd100;
    localparam logic [15:0] MAX_SPAN_MS  = 16'd60000;
    localparam logic [5:0]  MAX_PIN      = 6'd48;

    localparam logic [PIN_W-1:0] PIN_MASK_ALL = {PIN_W{1'b1}};

    localparam logic [0:0] CFG_PIN_MASK = 1'b0;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  act_kind;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [4:0]  blink_count_in;
        logic [15:0] span_ms_in;
        logic [5:0]  pin_in;
        logic        level_in;
        logic        ms_tick;
        logic        blinker_busy;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  fill_level;
        logic        busy_res;
        logic        issue_valid;
        logic [2:0]  issue_kind;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [4:0]  blink_count_out;
        logic [15:0] span_ms_out;
        logic [5:0]  pin_out;
        logic        level_out;
    } res_t;

    // one queued action, 54 bits
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [4:0]  count;
        logic [15:0] span;
        logic [5:0]  pin;
        logic        level;
    } entry_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsq_ctrl.sv =====
`default_nettype none

module tsq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    done,
    output tsq_pkg::ctrl_cmd_t      cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        done_next = cmd.exec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tsq_datapath.sv =====
`default_nettype none

module tsq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tsq_pkg::ctrl_cmd_t          cmd,
    input  wire tsq_pkg::req_t               req,
    input  wire logic [tsq_pkg::PIN_W-1:0]   pin_mask,
    output tsq_pkg::res_t                    res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    tsq_pkg::entry_t mem [QUEUE_DEPTH];
    tsq_pkg::entry_t rdata_reg;
    tsq_pkg::req_t   req_reg;
    tsq_pkg::res_t   res_reg;
    tsq_pkg::res_t   res_next;

    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wait_on_reg;
    logic             wait_on_next;
    logic [15:0]      wait_left_reg;
    logic [15:0]      wait_left_next;
    logic             blink_hold_reg;
    logic             blink_hold_next;

    logic [63:0]      mask_ext;
    logic             entry_ok;
    logic             wr_en;
    logic             held;
    logic [15:0]      wait_dec;
    tsq_pkg::entry_t  new_entry;

    always_comb
    begin
        mask_ext = {{(64 - tsq_pkg::PIN_W){1'b0}}, pin_mask};
        case (req_reg.act_kind)
            tsq_pkg::KIND_BLINK:
                entry_ok = (req_reg.blink_count_in != 5'd0)
                    && (req_reg.blink_count_in <= tsq_pkg::MAX_TIMES)
                    && (req_reg.span_ms_in >= tsq_pkg::MIN_BLINK_MS)
                    && (req_reg.span_ms_in <= tsq_pkg::MAX_SPAN_MS);
            tsq_pkg::KIND_PIN:
                entry_ok = (req_reg.pin_in <= tsq_pkg::MAX_PIN)
                    && mask_ext[req_reg.pin_in];
            tsq_pkg::KIND_WAIT:
                entry_ok = (req_reg.span_ms_in != 16'd0)
                    && (req_reg.span_ms_in <= tsq_pkg::MAX_SPAN_MS);
            default:
                entry_ok = 1'b1;
        endcase

        // store only the operands that the action kind uses
        new_entry      = '0;
        new_entry.kind = req_reg.act_kind;
        if (req_reg.act_kind == tsq_pkg::KIND_COLOR || req_reg.act_kind == tsq_pkg::KIND_BLINK)
        begin
            new_entry.red   = req_reg.red_in;
            new_entry.green = req_reg.green_in;
            new_entry.blue  = req_reg.blue_in;
        end
        if (req_reg.act_kind == tsq_pkg::KIND_BLINK)
        begin
            new_entry.count = req_reg.blink_count_in;
        end
        if (req_reg.act_kind == tsq_pkg::KIND_BLINK || req_reg.act_kind == tsq_pkg::KIND_WAIT)
        begin
            new_entry.span = req_reg.span_ms_in;
        end
        if (req_reg.act_kind == tsq_pkg::KIND_PIN)
        begin
            new_entry.pin   = req_reg.pin_in;
            new_entry.level = req_reg.level_in;
        end

        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        count_next      = count_reg;
        wait_on_next    = wait_on_reg;
        wait_left_next  = wait_left_reg;
        blink_hold_next = blink_hold_reg;
        wr_en           = 1'b0;
        held            = 1'b0;
        res_next        = '0;

        wait_dec = wait_left_reg;
        if (req_reg.ms_tick && wait_left_reg != 16'd0)
        begin
            wait_dec = wait_left_reg - 16'd1;
        end

        case (req_reg.op)
            tsq_pkg::OP_ENQUEUE:
            begin
                if (!entry_ok)
                begin
                    res_next.status = tsq_pkg::STATUS_RANGE;
                end
                else if (count_reg >= CNT_FULL)
                begin
                    res_next.status = tsq_pkg::STATUS_FULL;
                end
                else
                begin
                    wr_en       = cmd.exec;
                    wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            tsq_pkg::OP_CLEAR:
            begin
                rd_ptr_next          = '0;
                wr_ptr_next          = '0;
                count_next           = '0;
                wait_on_next         = 1'b0;
                wait_left_next       = '0;
                blink_hold_next      = 1'b0;
                res_next.issue_valid = 1'b1;
                res_next.issue_kind  = tsq_pkg::ISSUE_LED_OFF;
            end
            tsq_pkg::OP_STEP:
            begin
                if (wait_on_reg)
                begin
                    wait_left_next = wait_dec;
                    if (wait_dec != 16'd0)
                    begin
                        held = 1'b1;
                    end
                    else
                    begin
                        wait_on_next = 1'b0;
                    end
                end
                if (!held && blink_hold_reg)
                begin
                    if (req_reg.blinker_busy)
                    begin
                        held = 1'b1;
                    end
                    else
                    begin
                        blink_hold_next = 1'b0;
                    end
                end
                if (!held && count_reg != '0)
                begin
                    rd_ptr_next              = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                    count_next               = count_reg - 1'b1;
                    res_next.issue_valid     = 1'b1;
                    res_next.issue_kind      = {1'b0, rdata_reg.kind};
                    res_next.red_out         = rdata_reg.red;
                    res_next.green_out       = rdata_reg.green;
                    res_next.blue_out        = rdata_reg.blue;
                    res_next.blink_count_out = rdata_reg.count;
                    res_next.span_ms_out     = rdata_reg.span;
                    res_next.pin_out         = rdata_reg.pin;
                    res_next.level_out       = rdata_reg.level;
                    if (rdata_reg.kind == tsq_pkg::KIND_BLINK)
                    begin
                        blink_hold_next = 1'b1;
                    end
                    else if (rdata_reg.kind == tsq_pkg::KIND_WAIT)
                    begin
                        wait_on_next   = 1'b1;
                        wait_left_next = rdata_reg.span;
                    end
                end
            end
            default:
            begin
            end
        endcase

        res_next.fill_level = 5'(count_next);
        res_next.busy_res   = (req_reg.op != tsq_pkg::OP_CLEAR)
            && (count_next != '0 || wait_on_next || blink_hold_next || req_reg.blinker_busy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
            wait_on_reg    <= 1'b0;
            wait_left_reg  <= '0;
            blink_hold_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            count_reg      <= count_next;
            wait_on_reg    <= wait_on_next;
            wait_left_reg  <= wait_left_next;
            blink_hold_reg <= blink_hold_next;
        end
    end

    // head entry is fetched as the request is taken; no write is pending then
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= new_entry;
        end
        if (cmd.load)
        begin
            rdata_reg <= mem[rd_ptr_reg];
            req_reg   <= req;
        end
        if (cmd.exec)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/timed_action_sequencer_top.sv =====
`default_nettype none

// Channel   | Signals                                        | Handshake
// ----------+------------------------------------------------+------------------------------
// request   | start, busy, req (tsq_pkg::req_t)              | taken when start && !busy
// result    | done, res (tsq_pkg::res_t)                     | one cycle, marked by done
// config    | psel, penable, pwrite, paddr, pwdata, prdata   | APB, pready tied high
//
// A request has a take cycle, which fetches the FIFO head into a register, and an execute cycle,
// which updates queue and timers. The result is registered in the execute cycle and shows with
// busy already low, so the next request can be taken while the result is on the port.
// Reset clears pointers, count and timers at once; queue storage is never cleared.
// The receiver cannot stall the result.

module timed_action_sequencer_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire tsq_pkg::req_t        req,
    output logic                      done,
    output tsq_pkg::res_t             res,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [63:0]          pwdata,
    output logic [63:0]               prdata,
    output logic                      pready
);

    tsq_pkg::ctrl_cmd_t          cmd;
    logic [tsq_pkg::PIN_W-1:0]   pin_mask_reg;
    logic                        cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[3] == tsq_pkg::CFG_PIN_MASK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_mask_reg <= tsq_pkg::PIN_MASK_ALL;
        end
        else if (psel && penable && pwrite && cfg_hit)
        begin
            pin_mask_reg <= pwdata[tsq_pkg::PIN_W-1:0];
        end
    end

    assign prdata = cfg_hit ? {{(64 - tsq_pkg::PIN_W){1'b0}}, pin_mask_reg} : 64'd0;

    tsq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    tsq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .pin_mask (pin_mask_reg),
        .res      (res)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tsq_checker.sv =====
`default_nettype none

module tsq_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            busy,
    input  wire logic            done,
    input  wire tsq_pkg::res_t   res
);

    // a taken request occupies the block for the execute cycle
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request taken");

    a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after request");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_led_off: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.issue_kind == tsq_pkg::ISSUE_LED_OFF)
            |-> (res.fill_level == 5'd0 && !res.busy_res && res.issue_valid))
        else $error("LED off without empty idle queue");

    a_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !res.issue_valid)
            |-> (res.span_ms_out == 16'd0 && res.pin_out == 6'd0 && res.red_out == 8'd0))
        else $error("operands set without an issue");

endmodule

bind timed_action_sequencer_top tsq_checker u_tsq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .res   (res)
);

`default_nettype wire

// ===== verif/tb_timed_action_sequencer_top.sv =====
`timescale 1ns / 100ps

module tb_timed_action_sequencer_top;

    localparam int DEPTH = 16;
    // op code 3 has no name in the package: the block must ignore it
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct {
        tsq_pkg::req_t rq;
        bit            typed;
        tsq_pkg::res_t want;
    } dir_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    tsq_pkg::req_t              req = '0;
    logic                       done;
    tsq_pkg::res_t              res;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [3:0]                 paddr = '0;
    logic [63:0]                pwdata = '0;
    logic [63:0]                prdata;
    logic                       pready;

    // sequencer state as the testbench sees it
    tsq_pkg::entry_t            q_store [DEPTH];
    int unsigned                q_rd, q_wr, q_count;
    logic                       wait_on, blink_hold;
    logic [15:0]                wait_left;
    logic [tsq_pkg::PIN_W-1:0]  pin_mask;

    tsq_pkg::res_t              awaited_res [$];
    dir_row_t                   dir_tab [$];
    int                         err_cnt = 0;

    timed_action_sequencer_top #(
        .QUEUE_DEPTH (DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("tb_timed_action_sequencer_top: done, errors");
        $finish;
    end

    // Service one request against the local copy of the sequencer state.
    function automatic tsq_pkg::res_t apply_request(input tsq_pkg::req_t r);
        tsq_pkg::res_t   o;
        tsq_pkg::entry_t e;
        logic            ok;
        logic            held;
        o = '0;
        e = '0;
        case (r.op)
            tsq_pkg::OP_ENQUEUE:
            begin
                case (r.act_kind)
                    tsq_pkg::KIND_BLINK:
                        ok = r.blink_count_in >= 5'd1
                             && r.blink_count_in <= tsq_pkg::MAX_TIMES
                             && r.span_ms_in >= tsq_pkg::MIN_BLINK_MS
                             && r.span_ms_in <= tsq_pkg::MAX_SPAN_MS;
                    tsq_pkg::KIND_PIN:
                        ok = r.pin_in <= tsq_pkg::MAX_PIN && pin_mask[r.pin_in];
                    tsq_pkg::KIND_WAIT:
                        ok = r.span_ms_in >= 16'd1 && r.span_ms_in <= tsq_pkg::MAX_SPAN_MS;
                    default:
                        ok = 1'b1;
                endcase
                // field check wins over a full queue
                if (!ok)
                    o.status = tsq_pkg::STATUS_RANGE;
                else if (q_count >= DEPTH)
                    o.status = tsq_pkg::STATUS_FULL;
                else
                begin
                    e.kind = r.act_kind;
                    if (r.act_kind == tsq_pkg::KIND_COLOR || r.act_kind == tsq_pkg::KIND_BLINK)
                    begin
                        e.red   = r.red_in;
                        e.green = r.green_in;
                        e.blue  = r.blue_in;
                    end
                    if (r.act_kind == tsq_pkg::KIND_BLINK)
                        e.count = r.blink_count_in;
                    if (r.act_kind == tsq_pkg::KIND_BLINK || r.act_kind == tsq_pkg::KIND_WAIT)
                        e.span = r.span_ms_in;
                    if (r.act_kind == tsq_pkg::KIND_PIN)
                    begin
                        e.pin   = r.pin_in;
                        e.level = r.level_in;
                    end
                    q_store[q_wr] = e;
                    q_wr = (q_wr + 1) % DEPTH;
                    q_count++;
                end
            end
            tsq_pkg::OP_CLEAR:
            begin
                q_rd = 0;
                q_wr = 0;
                q_count = 0;
                wait_on = 1'b0;
                wait_left = '0;
                blink_hold = 1'b0;
                o.issue_valid = 1'b1;
                o.issue_kind = tsq_pkg::ISSUE_LED_OFF;
            end
            tsq_pkg::OP_STEP:
            begin
                held = 1'b0;
                if (wait_on)
                begin
                    if (r.ms_tick && wait_left != 0)
                        wait_left--;
                    if (wait_left != 0)
                        held = 1'b1;
                    else
                        wait_on = 1'b0;
                end
                if (!held && blink_hold)
                begin
                    if (r.blinker_busy)
                        held = 1'b1;
                    else
                        blink_hold = 1'b0;
                end
                if (!held && q_count > 0)
                begin
                    e = q_store[q_rd];
                    q_rd = (q_rd + 1) % DEPTH;
                    q_count--;
                    o.issue_valid     = 1'b1;
                    o.issue_kind      = {1'b0, e.kind};
                    o.red_out         = e.red;
                    o.green_out       = e.green;
                    o.blue_out        = e.blue;
                    o.blink_count_out = e.count;
                    o.span_ms_out     = e.span;
                    o.pin_out         = e.pin;
                    o.level_out       = e.level;
                    if (e.kind == tsq_pkg::KIND_BLINK)
                        blink_hold = 1'b1;
                    else if (e.kind == tsq_pkg::KIND_WAIT)
                    begin
                        wait_on = 1'b1;
                        wait_left = e.span;
                    end
                end
            end
            default: ;
        endcase
        o.fill_level = q_count[4:0];
        o.busy_res = (r.op != tsq_pkg::OP_CLEAR) &&
                     (q_count > 0 || wait_on || blink_hold || r.blinker_busy);
        return o;
    endfunction

    function automatic tsq_pkg::req_t mk_req(input logic [1:0] op, input logic [1:0] kind,
                                             input logic [7:0] red, input logic [7:0] green,
                                             input logic [7:0] blue, input logic [4:0] cnt,
                                             input logic [15:0] span, input logic [5:0] pin,
                                             input logic lvl, input logic tick,
                                             input logic bbusy);
        tsq_pkg::req_t r;
        r.op = op;
        r.act_kind = kind;
        r.red_in = red;
        r.green_in = green;
        r.blue_in = blue;
        r.blink_count_in = cnt;
        r.span_ms_in = span;
        r.pin_in = pin;
        r.level_in = lvl;
        r.ms_tick = tick;
        r.blinker_busy = bbusy;
        return r;
    endfunction

    function automatic tsq_pkg::res_t mk_res(input logic [1:0] status, input logic [4:0] fill,
                                             input logic bsy, input logic iv,
                                             input logic [2:0] ik);
        tsq_pkg::res_t o;
        o = '0;
        o.status = status;
        o.fill_level = fill;
        o.busy_res = bsy;
        o.issue_valid = iv;
        o.issue_kind = ik;
        return o;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        tsq_pkg::res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (awaited_res.size() == 0)
            begin
                $error("result strobe with no request outstanding");
                err_cnt++;
            end
            else
            begin
                want = awaited_res.pop_front();
                check_field("status", want.status, res.status);
                check_field("fill_level", want.fill_level, res.fill_level);
                check_field("busy_res", want.busy_res, res.busy_res);
                check_field("issue_valid", want.issue_valid, res.issue_valid);
                check_field("issue_kind", want.issue_kind, res.issue_kind);
                check_field("red_out", want.red_out, res.red_out);
                check_field("green_out", want.green_out, res.green_out);
                check_field("blue_out", want.blue_out, res.blue_out);
                check_field("blink_count_out", want.blink_count_out, res.blink_count_out);
                check_field("span_ms_out", want.span_ms_out, res.span_ms_out);
                check_field("pin_out", want.pin_out, res.pin_out);
                check_field("level_out", want.level_out, res.level_out);
            end
        end
    end

    // Start stays high on return so back-to-back requests need no extra edge.
    task automatic send_req(input tsq_pkg::req_t r, input bit typed, input tsq_pkg::res_t want);
        tsq_pkg::res_t model;
        req <= r;
        start <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        model = apply_request(r);
        awaited_res.push_back(typed ? want : model);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (awaited_res.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pin_mask(input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {tsq_pkg::CFG_PIN_MASK, 3'd0};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pin_mask = val[tsq_pkg::PIN_W-1:0];
    endtask

    task automatic run_random(input int n);
        tsq_pkg::req_t r;
        logic [63:0]   bits;
        int            roll, enq_pct, gap_pct, bb_pct, tick_pct, p;
        enq_pct = 45;
        gap_pct = 15;
        bb_pct = 50;
        tick_pct = 70;
        for (int i = 0; i < n; i++)
        begin
            // new traffic mix every 40 requests: fill-heavy, drain-heavy, gap-free...
            if (i % 40 == 0)
            begin
                roll = $urandom_range(2);
                enq_pct = roll == 0 ? 20 : roll == 1 ? 45 : 70;
                roll = $urandom_range(2);
                gap_pct = roll == 0 ? 0 : roll == 1 ? 15 : 40;
                bb_pct = $urandom_range(1) ? 15 : 75;
                tick_pct = $urandom_range(1) ? 30 : 90;
            end
            bits = {$urandom, $urandom};
            r = bits[$bits(tsq_pkg::req_t)-1:0];
            roll = $urandom_range(99);
            if (roll < 2)
                r.op = tsq_pkg::OP_CLEAR;
            else if (roll < 3)
                r.op = OP_NONE;
            else if (roll < 3 + enq_pct)
                r.op = tsq_pkg::OP_ENQUEUE;
            else
                r.op = tsq_pkg::OP_STEP;
            if (r.op == tsq_pkg::OP_ENQUEUE && $urandom_range(99) >= 15)
            begin
                r.blink_count_in = 5'($urandom_range(1, tsq_pkg::MAX_TIMES));
                if (r.act_kind == tsq_pkg::KIND_BLINK)
                    r.span_ms_in = 16'($urandom_range(tsq_pkg::MIN_BLINK_MS,
                                                      tsq_pkg::MAX_SPAN_MS));
                else
                begin
                    roll = $urandom_range(99);
                    // mostly short waits so the queue keeps moving
                    r.span_ms_in = 16'(roll < 88 ? $urandom_range(1, 6) :
                                       roll < 98 ? $urandom_range(7, 300) :
                                       $urandom_range(301, tsq_pkg::MAX_SPAN_MS));
                end
                p = $urandom_range(tsq_pkg::MAX_PIN);
                for (int t = 0; t < 8 && !pin_mask[p]; t++)
                    p = $urandom_range(tsq_pkg::MAX_PIN);
                r.pin_in = 6'(p);
            end
            r.ms_tick = $urandom_range(99) < tick_pct;
            r.blinker_busy = $urandom_range(99) < bb_pct;
            send_req(r, 1'b0, '0);
            if ($urandom_range(99) < gap_pct)
                hold_off($urandom_range(9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 3));
        end
    endtask

    initial
    begin
        q_rd = 0;
        q_wr = 0;
        q_count = 0;
        wait_on = 1'b0;
        wait_left = '0;
        blink_hold = 1'b0;
        pin_mask = tsq_pkg::PIN_MASK_ALL;
        foreach (q_store[i])
            q_store[i] = '0;

        dir_tab.push_back('{mk_req(tsq_pkg::OP_STEP, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                            mk_res(tsq_pkg::STATUS_OK, 0, 0, 0, 0)});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_STEP, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 0, 1), 1,
                            mk_res(tsq_pkg::STATUS_OK, 0, 1, 0, 0)});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_CLEAR, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 0, 1), 1,
                            mk_res(tsq_pkg::STATUS_OK, 0, 0, 1, tsq_pkg::ISSUE_LED_OFF)});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_BLINK,
                                   9, 9, 9, 0, 1000, 0, 0, 0, 0), 1,
                            mk_res(tsq_pkg::STATUS_RANGE, 0, 0, 0, 0)});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_BLINK,
                                   9, 9, 9, 21, 1000, 0, 0, 0, 0), 1,
                            mk_res(tsq_pkg::STATUS_RANGE, 0, 0, 0, 0)});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_BLINK,
                                   9, 9, 9, 5, 99, 0, 0, 0, 0), 1,
                            mk_res(tsq_pkg::STATUS_RANGE, 0, 0, 0, 0)});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_WAIT,
                                   0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                            mk_res(tsq_pkg::STATUS_RANGE, 0, 0, 0, 0)});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_WAIT,
                                   0, 0, 0, 0, 65535, 0, 0, 0, 0), 1,
                            mk_res(tsq_pkg::STATUS_RANGE, 0, 0, 0, 0)});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_PIN,
                                   0, 0, 0, 0, 0, 49, 1, 0, 0), 1,
                            mk_res(tsq_pkg::STATUS_RANGE, 0, 0, 0, 0)});
        // color ignores out-of-range count, span and pin
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_COLOR,
                                   255, 255, 255, 31, 0, 63, 1, 1, 0), 1,
                            mk_res(tsq_pkg::STATUS_OK, 1, 1, 0, 0)});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_BLINK,
                                   255, 0, 128, 20, 60000, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_BLINK,
                                   0, 255, 1, 1, 100, 63, 1, 0, 0), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_PIN,
                                   255, 255, 255, 31, 65535, 48, 1, 0, 0), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_PIN,
                                   0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_WAIT,
                                   0, 0, 0, 0, 1, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_ENQUEUE, tsq_pkg::KIND_WAIT,
                                   7, 7, 7, 7, 60000, 7, 1, 0, 0), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_STEP, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_STEP, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 0, 1), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_STEP, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 1, 1), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_STEP, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_STEP, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_STEP, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 1, 0), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_STEP, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_STEP, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        // wait reaches zero on this tick and ends, next action goes out
        dir_tab.push_back('{mk_req(tsq_pkg::OP_STEP, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 1, 0), 0, '0});
        dir_tab.push_back('{mk_req(OP_NONE, tsq_pkg::KIND_WAIT,
                                   1, 2, 3, 4, 5, 6, 1, 1, 1), 0, '0});
        dir_tab.push_back('{mk_req(tsq_pkg::OP_CLEAR, tsq_pkg::KIND_COLOR,
                                   0, 0, 0, 0, 0, 0, 0, 1, 1), 1,
                            mk_res(tsq_pkg::STATUS_OK, 0, 0, 1, tsq_pkg::ISSUE_LED_OFF)});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);
        run_random(400);
        drain();

        write_pin_mask({$urandom, $urandom});
        run_random(400);
        drain();

        write_pin_mask('0);
        run_random(250);
        drain();

        write_pin_mask({15'd0, tsq_pkg::PIN_MASK_ALL});
        run_random(400);
        drain();

        write_pin_mask(64'd1 << tsq_pkg::MAX_PIN);
        run_random(200);
        drain();

        write_pin_mask({$urandom, $urandom});
        run_random(170);
        drain();

        if (err_cnt == 0)
            $display("tb_timed_action_sequencer_top: done, clean");
        else
            $display("tb_timed_action_sequencer_top: done, errors");
        $finish;
    end

endmodule

// ===== timed_action_sequencer_top.f =====
hw/rtl/tsq_pkg.sv
hw/rtl/tsq_ctrl.sv
hw/rtl/tsq_datapath.sv
hw/rtl/timed_action_sequencer_top.sv
hw/rtl/tsq_checker.sv
verif/tb_timed_action_sequencer_top.sv
